[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the hue rotator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

[hdl/rgbhr_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhr_pkg
// Constants, types and helpers for the RGB hue rotator.
// ----------------------------------------------------------------------------
package rgbhr_pkg;
    localparam int HUE_FRAC_BITS = 8;
    localparam int ONE  = 1 << HUE_FRAC_BITS;
    localparam int SEXT = 60 * ONE;
    localparam int FULL = 360 * ONE;
    localparam int HW   = $clog2(FULL);
    localparam int QD   = 4;
    localparam int QAW  = $clog2(QD);

    typedef logic [7:0] chan_t;
    typedef logic signed [9:0] shift_t;

    typedef struct packed {
        chan_t       mx;
        chan_t       mn;
        chan_t       d;
        logic [1:0]  base;
        logic        negative;
        logic [7:0]  num;
        logic        grey;
        chan_t       r;
        chan_t       g;
        chan_t       b;
    } cls_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    localparam logic [1:0] BASE_R = 2'd0;
    localparam logic [1:0] BASE_G = 2'd1;
    localparam logic [1:0] BASE_B = 2'd2;
endpackage

[hdl/rgbhr_front.sv]
// ----------------------------------------------------------------------------
// rgbhr_front
// Accepts a color and classifies it: max, min, chroma, sextant base, sign.
// ----------------------------------------------------------------------------
module rgbhr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rgbhr_pkg::rgb_t in_rgb,
    output logic            cls_valid,
    input  logic            cls_ready,
    output rgbhr_pkg::cls_t cls
);
    import rgbhr_pkg::*;

    logic valid_reg;
    cls_t cls_reg;
    cls_t cls_next;
    chan_t mx, mn, pos, neg;

    assign in_ready = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls = cls_reg;

    always_comb
    begin
        mx = in_rgb.r;
        mn = in_rgb.r;
        if (in_rgb.g > mx) mx = in_rgb.g;
        if (in_rgb.b > mx) mx = in_rgb.b;
        if (in_rgb.g < mn) mn = in_rgb.g;
        if (in_rgb.b < mn) mn = in_rgb.b;
        cls_next.mx = mx;
        cls_next.mn = mn;
        cls_next.d = mx - mn;
        cls_next.grey = (mx == mn);
        cls_next.r = in_rgb.r;
        cls_next.g = in_rgb.g;
        cls_next.b = in_rgb.b;
        if (mx == in_rgb.r)
        begin
            cls_next.base = BASE_R; pos = in_rgb.g; neg = in_rgb.b;
        end
        else if (mx == in_rgb.g)
        begin
            cls_next.base = BASE_G; pos = in_rgb.b; neg = in_rgb.r;
        end
        else
        begin
            cls_next.base = BASE_B; pos = in_rgb.r; neg = in_rgb.g;
        end
        cls_next.negative = pos < neg;
        cls_next.num = (pos >= neg) ? pos - neg : neg - pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cls_reg <= cls_next;
    end
endmodule

[hdl/rgbhr_queue.sv]
// ----------------------------------------------------------------------------
// rgbhr_queue
// Small FIFO decoupling classification from the hue rebuild pipeline.
// ----------------------------------------------------------------------------
module rgbhr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rgbhr_pkg::cls_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rgbhr_pkg::cls_t rd_data
);
    import rgbhr_pkg::*;
`include "assert_macros.svh"

    cls_t mem [QD];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != QAW'(0) + (QAW+1)'(QD);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    `ASSERT_NEVER(a_cnt_range, cnt_reg > (QAW+1)'(QD), "queue overfilled")
    `ASSERT_CLK(a_ptr_gap, (wp_reg - rp_reg) == cnt_reg[QAW-1:0], "pointer/count mismatch")
    `ASSERT_CLK(a_cnt_step, wr && !rd |=> cnt_reg == $past(cnt_reg) + 1'b1, "count step")
endmodule

[hdl/rgbhr_back.sv]
// ----------------------------------------------------------------------------
// rgbhr_back
// Hue rebuild pipeline: divide, rotate/wrap, intermediate channel, sectors.
// ----------------------------------------------------------------------------
module rgbhr_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [9:0]       shift,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rgbhr_pkg::cls_t         cls,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rgbhr_pkg::rgb_t         out_rgb
);
    import rgbhr_pkg::*;
`include "assert_macros.svh"

    localparam int DW = 8 + 6 + HUE_FRAC_BITS;
    localparam int NS = 8;
    localparam int PS = NS + 7;
    // 2*SEXT = 15 << (HUE_FRAC_BITS+3); divide by 15 by reciprocal, exact below 4681
    localparam int XSH = HUE_FRAC_BITS + 3;
    localparam int XRCP = 4370;

    logic adv;
    logic [PS-1:0] v_reg;

    assign adv = !v_reg[PS-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[PS-1];

    cls_t c_reg [PS-1];
    logic [DW-1:0] rem_reg [NS+1];
    logic [DW-1:0] q_reg [NS+1];

    // stage 0: load dividend 60*num*ONE; restoring division one quotient bit a time
    // bits per stage covers DW quotient bits over NS stages
    localparam int BPS = (DW + NS - 1) / NS;

    logic [DW-1:0] rem_n [NS];
    logic [DW-1:0] q_n [NS];
    logic [2*DW-1:0] pr;

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            rem_n[s] = rem_reg[s];
            q_n[s] = q_reg[s];
            for (int j = 0; j < BPS; j++)
            begin
                if ((s*BPS + j) < DW)
                begin
                    pr = {rem_n[s], q_n[s]} << 1;
                    rem_n[s] = pr[2*DW-1:DW];
                    q_n[s] = pr[DW-1:0];
                    if (rem_n[s] >= DW'(c_reg[s].d))
                    begin
                        rem_n[s] = rem_n[s] - DW'(c_reg[s].d);
                        q_n[s][0] = 1'b1;
                    end
                end
            end
        end
    end

    logic [DW-1:0] dividend;
    assign dividend = DW'(in_valid ? cls.num : 8'd0) * DW'(60) << HUE_FRAC_BITS;

    logic [HW:0] hue_reg;
    logic [HW+1:0] tot_reg;
    logic [HW-1:0] h_reg;
    logic [2:0] k_reg, k2_reg;
    logic [HW-1:0] t_reg;
    logic [8+HW:0] prod_reg;
    rgb_t o_reg;

    logic [HW:0] hue_n;
    logic signed [HW+2:0] tot_n;
    logic [HW+1:0] tw;
    logic [HW-1:0] h_n;
    logic [HW-1:0] f;
    logic [2:0] k_n;
    logic [8+HW+1:0] xnum;
    logic [11:0] xm;
    logic [24:0] xq;
    chan_t xv;
    rgb_t o_n;

    always_comb
    begin
        hue_n = (HW+1)'(q_reg[NS]);
        case (c_reg[NS].base)
            BASE_R: hue_n = c_reg[NS].negative ? (HW+1)'(FULL) - (HW+1)'(q_reg[NS])
                                              : (HW+1)'(q_reg[NS]);
            BASE_G: hue_n = c_reg[NS].negative ? (HW+1)'(120*ONE) - (HW+1)'(q_reg[NS])
                                              : (HW+1)'(120*ONE) + (HW+1)'(q_reg[NS]);
            default: hue_n = c_reg[NS].negative ? (HW+1)'(240*ONE) - (HW+1)'(q_reg[NS])
                                               : (HW+1)'(240*ONE) + (HW+1)'(q_reg[NS]);
        endcase
        if (c_reg[NS].grey)
            hue_n = '0;
        // shift in -512..511 deg; offset by 720 then bring into range
        tot_n = $signed({2'b0, hue_reg}) + ((HW+3)'(shift) <<< HUE_FRAC_BITS)
              + (HW+3)'(720*ONE);
        tw = tot_reg;
        for (int i = 1; i < 5; i++)
            if (tot_reg >= (HW+2)'(i*FULL)) tw = tot_reg - (HW+2)'(i*FULL);
        h_n = HW'(tw);
        k_n = 3'd0;
        for (int i = 1; i < 6; i++)
            if (h_reg >= HW'(i*SEXT)) k_n = 3'(i);
        f = h_reg - HW'(k_n) * HW'(SEXT);
        xnum = {prod_reg, 1'b0} + (9+HW+1)'(SEXT);
        xm = 12'(xnum >> XSH);
        xq = 25'(xm) * 25'(XRCP);
        xv = c_reg[PS-2].mn + xq[23:16];
        case (k2_reg)
            3'd0: o_n = '{c_reg[PS-2].mx, xv, c_reg[PS-2].mn};
            3'd1: o_n = '{xv, c_reg[PS-2].mx, c_reg[PS-2].mn};
            3'd2: o_n = '{c_reg[PS-2].mn, c_reg[PS-2].mx, xv};
            3'd3: o_n = '{c_reg[PS-2].mn, xv, c_reg[PS-2].mx};
            3'd4: o_n = '{xv, c_reg[PS-2].mn, c_reg[PS-2].mx};
            default: o_n = '{c_reg[PS-2].mx, c_reg[PS-2].mn, xv};
        endcase
        if (c_reg[PS-2].grey)
            o_n = '{c_reg[PS-2].r, c_reg[PS-2].g, c_reg[PS-2].b};
    end

    assign out_rgb = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[PS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0] <= cls;
            rem_reg[0] <= '0;
            q_reg[0] <= dividend;
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s+1] <= rem_n[s];
                q_reg[s+1] <= q_n[s];
            end
            for (int s = 1; s < PS-1; s++)
                c_reg[s] <= c_reg[s-1];
            hue_reg <= hue_n;
            tot_reg <= (HW+2)'(tot_n);
            h_reg <= h_n;
            k_reg <= k_n;
            t_reg <= k_n[0] ? HW'(SEXT) - f : f;
            prod_reg <= (9+HW)'(c_reg[NS+4].d) * (9+HW)'(t_reg);
            k2_reg <= k_reg;
            o_reg <= o_n;
        end
    end

    `ASSERT_CLK(a_hold, out_valid && !out_ready |=> out_valid && $stable(o_reg), "output dropped")
    `ASSERT_NEVER(a_k_range, v_reg[NS+4] && k_reg > 3'd5, "sextant out of range")
    `ASSERT_NEVER(a_h_range, v_reg[NS+3] && h_reg >= HW'(FULL), "hue not wrapped")
endmodule

[hdl/rgb_hue_rotator_unit.sv]
// ----------------------------------------------------------------------------
// rgb_hue_rotator_unit
// RGB hue rotator: configurable signed angle, one color/clock unless stalled.
// ----------------------------------------------------------------------------
// Accepts one color per clock while the output is not stalled and returns the
// rotated color through the classifier register, the queue, a load stage,
// the eight divider stages and six rebuild stages. A stalled output freezes
// the rebuild pipeline; the 4-entry queue between the classifier and the
// pipeline absorbs stalls.
module rgb_hue_rotator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_result,
    output logic [7:0]  green_result,
    output logic [7:0]  blue_result
);
    import rgbhr_pkg::*;

    shift_t shift_reg;
    cls_t f_cls, q_cls;
    logic f_valid, f_ready, q_valid, q_ready;
    rgb_t o;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_reg <= '0;
        else if (cfg_we)
            shift_reg <= cfg_wdata;
    end

    rgbhr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_rgb({red_in, green_in, blue_in}),
        .cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls)
    );

    rgbhr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_cls), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cls)
    );

    rgbhr_back u_back (
        .clk(clk), .rst_n(rst_n), .shift(shift_reg), .in_valid(q_valid),
        .in_ready(q_ready), .cls(q_cls), .out_valid(out_valid),
        .out_ready(out_ready), .out_rgb(o)
    );

    assign red_result = o.r;
    assign green_result = o.g;
    assign blue_result = o.b;
endmodule
